>>> rtl/sws_pkg.sv
// Shared widths, register indexes and divider interface types for the sliding window variance block.
package sws_pkg;

  localparam int SAMPLE_W           = 16;
  localparam int INIT_W             = 32;
  localparam int WLEN_W             = 7;
  localparam int SQ_W               = 48;
  localparam int VAR_W              = 54;
  localparam int DEV_W              = SAMPLE_W + 9;
  localparam int DIV_W              = VAR_W;
  localparam int VAR_STEPS          = DIV_W / 2;
  localparam int DIV_STEP_W         = $clog2(DIV_W / 2 + 1);
  localparam int DEFAULT_WINDOW     = 16;
  localparam int DEFAULT_MAX_WINDOW = 64;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SQUARE = CFG_IDX_W'(1);

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_nz;
  } div_rsp_t;

endpackage

>>> rtl/sws_ring.sv
// History ring memory with per-entry valid bits; unwritten entries read as the fill value.
module sws_ring #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic [WIDTH-1:0]         fill_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [DEPTH-1:0] valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : fill_i;

endmodule

>>> rtl/sws_div.sv
// Serial restoring divider, two quotient bits per cycle, shared by the mean and the variance.
module sws_div
  import sws_pkg::*;
#(
  parameter int DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output div_rsp_t         rsp_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic [DIV_W-1:0]      quo_q;
  logic [DVS_W-1:0]      rem_q;
  logic [DVS_W-1:0]      d_q;
  logic [DIV_STEP_W-1:0] cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [DVS_W:0]   t1, t2;
  logic [DVS_W-1:0] r1, r2;
  logic             ge1, ge2;

  // two restoring steps per cycle
  always_comb begin
    t1  = {rem_q, quo_q[DIV_W-1]};
    ge1 = t1 >= {1'b0, d_q};
    r1  = ge1 ? DVS_W'(t1 - {1'b0, d_q}) : DVS_W'(t1);
    t2  = {r1, quo_q[DIV_W-2]};
    ge2 = t2 >= {1'b0, d_q};
    r2  = ge2 ? DVS_W'(t2 - {1'b0, d_q}) : DVS_W'(t2);
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      d_q   <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-3:0], ge1, ge2};
      rem_q <= r2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_STEP_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_STEP_W'(1);
        if (cnt_q == DIV_STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.rem_nz = |rem_q;
  assign quotient_o   = quo_q;

`ifndef NO_ASSERTIONS
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");
`endif

endmodule

>>> rtl/sliding_window_variance_top.sv
// Top level of the sliding window variance block: sequencer, arithmetic and configuration.
//
// Takes one signed 16-bit sample per item and returns one 54-bit Q.16 variance per item:
// the sum of the last N squared deviations from the Q.8 window mean, divided by N-1 and
// truncated. N is window_length, clamped to 2..MAX_WINDOW; both history rings live in
// single-port-read memories with a registered read. Items are handled one at a time; the
// shared divider retires two quotient bits per cycle and runs twice per item (floor mean,
// then variance). A finished result waits in the output register, so the next item is
// accepted while it is still pending. Writing a known register reloads everything in the
// same cycle: the sample ring reads as zero, the square ring reads as initial_square and
// the running total becomes N * initial_square; there is no clearing pass. Write registers
// only while the block is idle.
module sliding_window_variance_top
  import sws_pkg::*;
#(
  parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic        [VAR_W-1:0]     variance_o,
  input  logic                        cfg_we_i,
  input  logic        [CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int N_W        = $clog2(MAX_WINDOW + 1);
  localparam int SP_W       = $clog2(MAX_WINDOW);
  localparam int RP_W       = N_W;
  localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW) + 1;
  localparam int MAG_W      = SUM_W + 8;
  localparam int MEAN_STEPS = (MAG_W + 1) / 2;
  localparam int MEAN_SHIFT = DIV_W - 2 * MEAN_STEPS;
  localparam int CMP_W      = (N_W > WLEN_W) ? N_W : WLEN_W;
  localparam int N_RESET    = (DEFAULT_WINDOW > MAX_WINDOW) ? MAX_WINDOW : DEFAULT_WINDOW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_SQUARE,
    S_TOTAL,
    S_VAR_GO,
    S_VAR_WAIT,
    S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic [VAR_W-1:0] out_q;
  logic   out_load;

  // configuration and running state
  logic [WLEN_W-1:0]       window_q;
  logic [INIT_W-1:0]       init_q;
  logic [N_W-1:0]          n_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SP_W-1:0]         sp_q, sp_next;
  logic [RP_W-1:0]         rp_q, rp_next, rp_next_q;
  logic [VAR_W-1:0]        total_q, total_d;

  // item datapath
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [SQ_W-1:0]            oldest_q;
  logic signed [DEV_W-1:0]    dev_q, dev_d;
  logic [SQ_W-1:0]            sq_q;

  logic                        in_accept;
  logic                        cfg_hit;
  logic [WLEN_W-1:0]           wlen_new;
  logic [INIT_W-1:0]           init_new;
  logic [CMP_W-1:0]            wl_ext;
  logic [N_W-1:0]              n_new;
  logic [N_W+INIT_W-1:0]       reload_total;
  logic [RP_W:0]               rp_inc;
  logic [N_W:0]                sp_inc;
  logic [SAMPLE_W-1:0]         old_sample_raw;
  logic signed [SAMPLE_W-1:0]  old_sample;
  logic [SQ_W-1:0]             oldest_w;
  logic signed [MAG_W-1:0]     scaled;
  logic [MAG_W-1:0]            mag;
  logic [DEV_W-1:0]            quo_low;
  logic signed [DEV_W-1:0]     mean_q8;
  logic signed [DEV_W-1:0]     val_q8;
  logic signed [2*DEV_W-1:0]   dev_sq;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [DIV_W-1:0] div_dividend;
  logic [N_W-1:0]   div_divisor;
  logic [DIV_W-1:0] div_quo;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign variance_o  = out_q;
  // load the result once the output register is free
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Decode a register write and form the reloaded window length and total.
  always_comb begin
    wlen_new = window_q;
    init_new = init_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LENGTH: begin
          wlen_new = cfg_data_i[WLEN_W-1:0];
          cfg_hit  = 1'b1;
        end
        REG_INITIAL_SQUARE: begin
          init_new = cfg_data_i[INIT_W-1:0];
          cfg_hit  = 1'b1;
        end
        default: ;
      endcase
    end
    // clamp N to 2..MAX_WINDOW; the register keeps the raw bits
    wl_ext = CMP_W'(wlen_new);
    priority if (wl_ext < CMP_W'(2)) begin
      n_new = N_W'(2);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      n_new = N_W'(MAX_WINDOW);
    end else begin
      n_new = N_W'(wl_ext);
    end
    reload_total = n_new * init_new;
  end

  // Ring positions: samples wrap at N, squared deviations at N+1.
  always_comb begin
    sp_inc  = (N_W + 1)'(sp_q) + (N_W + 1)'(1);
    sp_next = (sp_inc >= (N_W + 1)'(n_q)) ? '0 : SP_W'(sp_inc);
    rp_inc  = (RP_W + 1)'(rp_q) + (RP_W + 1)'(1);
    rp_next = (rp_inc > (RP_W + 1)'(n_q)) ? '0 : RP_W'(rp_inc);
  end

  // Arithmetic of one item.
  always_comb begin
    old_sample = signed'(old_sample_raw);
    sum_d      = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
    // mean_q8 = floor(sum * 256 / N): divide the magnitude, then fix the sign
    scaled     = {sum_q, 8'b0};
    mag        = sum_q[SUM_W-1] ? MAG_W'(-scaled) : MAG_W'(scaled);
    quo_low    = div_quo[DEV_W-1:0];
    if (sum_q[SUM_W-1]) begin
      mean_q8 = div_rsp.rem_nz ? signed'(~quo_low) : signed'(-quo_low);
    end else begin
      mean_q8 = signed'(quo_low);
    end
    val_q8  = {sample_q[SAMPLE_W-1], sample_q, 8'b0};
    dev_d   = val_q8 - mean_q8;
    dev_sq  = dev_q * dev_q;
    total_d = total_q - VAR_W'(oldest_q) + VAR_W'(sq_q);
  end

  // Divider requests: mean first, then the variance.
  always_comb begin
    div_req.start = (state_q == S_MEAN_GO) || (state_q == S_VAR_GO);
    if (state_q == S_MEAN_GO) begin
      div_req.steps = DIV_STEP_W'(MEAN_STEPS);
      div_dividend  = DIV_W'(mag) << MEAN_SHIFT;
      div_divisor   = n_q;
    end else begin
      div_req.steps = DIV_STEP_W'(VAR_STEPS);
      div_dividend  = DIV_W'(total_q);
      div_divisor   = n_q - N_W'(1);
    end
  end

  // Running state; a register write reloads it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WLEN_W'(DEFAULT_WINDOW);
      init_q    <= '0;
      n_q       <= N_W'(N_RESET);
      sum_q     <= '0;
      sp_q      <= '0;
      rp_q      <= '0;
      rp_next_q <= '0;
      total_q   <= '0;
    end else if (cfg_hit) begin
      window_q  <= wlen_new;
      init_q    <= init_new;
      n_q       <= n_new;
      sum_q     <= '0;
      sp_q      <= '0;
      rp_q      <= '0;
      rp_next_q <= '0;
      total_q   <= VAR_W'(reload_total);
    end else begin
      if (in_accept) begin
        rp_next_q <= rp_next;
      end
      if (state_q == S_READ) begin
        sum_q <= sum_d;
        sp_q  <= sp_next;
      end
      if (state_q == S_TOTAL) begin
        total_q <= total_d;
        rp_q    <= rp_next_q;
      end
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
    end
    if (state_q == S_READ) begin
      oldest_q <= oldest_w;
    end
    if ((state_q == S_MEAN_WAIT) && div_rsp.done) begin
      dev_q <= dev_d;
    end
    if (state_q == S_SQUARE) begin
      sq_q <= dev_sq[SQ_W-1:0];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= div_quo[VAR_W-1:0];
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_READ;
          end
        end
        S_READ:    state_q <= S_MEAN_GO;
        S_MEAN_GO: state_q <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (div_rsp.done) begin
            state_q <= S_SQUARE;
          end
        end
        S_SQUARE:  state_q <= S_TOTAL;
        S_TOTAL:   state_q <= S_VAR_GO;
        S_VAR_GO:  state_q <= S_VAR_WAIT;
        S_VAR_WAIT: begin
          if (div_rsp.done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Sample history: read the oldest sample at acceptance, overwrite it next cycle.
  sws_ring #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_sample_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_hit),
    .wr_en_i   (state_q == S_READ),
    .wr_addr_i (sp_q),
    .wr_data_i (sample_q),
    .rd_en_i   (in_accept),
    .rd_addr_i (sp_q),
    .fill_i    ('0),
    .rd_data_o (old_sample_raw)
  );

  // Squared-deviation history: read one ahead of the write position.
  sws_ring #(
    .WIDTH (SQ_W),
    .DEPTH (MAX_WINDOW + 1)
  ) u_square_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_hit),
    .wr_en_i   (state_q == S_TOTAL),
    .wr_addr_i (rp_q),
    .wr_data_i (sq_q),
    .rd_en_i   (in_accept),
    .rd_addr_i (rp_next),
    .fill_i    (SQ_W'(init_q)),
    .rd_data_o (oldest_w)
  );

  sws_div #(
    .DVS_W (N_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .rsp_o      (div_rsp),
    .quotient_o (div_quo)
  );

`ifndef NO_ASSERTIONS
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  a_done_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_MEAN_WAIT || state_q == S_VAR_WAIT))
    else $error("divider finished outside a wait state");

  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_rsp.busy)
    else $error("divider busy while waiting for an item");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_OUT)
    else $error("result raised outside the output state");

  a_positions : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (N_W'(sp_q) < n_q) && (rp_q <= n_q))
    else $error("ring position outside the window");
`endif

endmodule
